>>> rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Item types, queue command type, codes and the back-end state encoding.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned KEY_CNT_W = 9;

  typedef enum logic {
    KIND_KEY  = 1'b0,
    KIND_DATA = 1'b1
  } kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           value;
    logic                 last;
    logic                 restart;
    logic                 store;
    logic                 sched;
    logic [KEY_CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_RD_T,
    ST_OUT
  } state_e;

endpackage

>>> rtl/rc4_front.sv
// ----------------------------------------------------------------------------
// RC4 front end
// Accepts beats and classifies them into key-store, schedule and data commands.
// ----------------------------------------------------------------------------
module rc4_front import rc4_pkg::*; #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  localparam int unsigned CNT_W = $clog2(KEY_MAX + 1);

  logic             key_open_q, key_open_d;
  logic [CNT_W-1:0] key_count_q, key_count_d;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_new;
  logic             store;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    cnt_base    = key_open_q ? key_count_q : '0;
    store       = (cnt_base < CNT_W'(KEY_MAX));
    cnt_new     = store ? cnt_base + CNT_W'(1) : cnt_base;
    key_open_d  = key_open_q;
    key_count_d = key_count_q;
    if (q_push_o) begin
      if (in_item_i.kind == KIND_KEY) begin
        key_open_d  = !in_item_i.last;
        key_count_d = cnt_new;
      end else begin
        key_open_d = 1'b0;
      end
    end
    q_cmd_o.kind    = kind_e'(in_item_i.kind);
    q_cmd_o.value   = in_item_i.value;
    q_cmd_o.last    = in_item_i.last;
    q_cmd_o.restart = !key_open_q;
    q_cmd_o.store   = store;
    q_cmd_o.sched   = in_item_i.last;
    q_cmd_o.count   = KEY_CNT_W'(cnt_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_open_q  <= 1'b0;
      key_count_q <= '0;
    end else begin
      key_open_q  <= key_open_d;
      key_count_q <= key_count_d;
    end
  end

endmodule

>>> rtl/rc4_fifo.sv
// ----------------------------------------------------------------------------
// RC4 command queue
// Two-entry queue between the front end and the cipher engine.
// ----------------------------------------------------------------------------
module rc4_fifo import rc4_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/rc4_core.sv
// ----------------------------------------------------------------------------
// RC4 cipher engine
// Key store, single-port permutation memory, key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_core import rc4_pkg::*; #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  state_e               state_q, state_d;
  logic [7:0]           gi_q, gi_d;
  logic [7:0]           j_q, j_d;
  logic [7:0]           a_q, a_d;
  logic [7:0]           sa_q, sa_d;
  logic [7:0]           sb_q, sb_d;
  logic [7:0]           value_q, value_d;
  logic                 last_q, last_d;
  logic                 sched_q, sched_d;
  logic [KEY_CNT_W-1:0] len_q, len_d;
  logic [KEY_CNT_W-1:0] kidx_q, kidx_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  logic [7:0]           perm_mem [256];
  logic [255:0]         perm_vld_q;
  logic                 perm_clr;
  logic                 mem_we;
  logic                 mem_re;
  logic [7:0]           mem_addr;
  logic [7:0]           mem_wdata;
  logic [7:0]           rd_data_q;
  logic [7:0]           rd_addr_q;
  logic                 rd_vld_q;
  logic [7:0]           s_rdata;

  logic [7:0]           key_mem [KEY_MAX];
  logic                 key_we;
  logic [KEY_CNT_W-1:0] key_waddr;
  logic [7:0]           key_rd_q;
  logic [7:0]           j_new;

  assign s_rdata     = rd_vld_q ? rd_data_q : rd_addr_q;
  assign j_new       = j_q + s_rdata + (sched_q ? key_rd_q : 8'd0);
  assign key_waddr   = q_cmd_i.count - KEY_CNT_W'(1);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data_q <= perm_mem[mem_addr];
      rd_vld_q  <= perm_vld_q[mem_addr];
      rd_addr_q <= mem_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_vld_q <= '0;
    end else if (perm_clr) begin
      perm_vld_q <= '0;
    end else if (mem_we) begin
      perm_vld_q[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr[KIDX_W-1:0]] <= q_cmd_i.value;
    end
    key_rd_q <= key_mem[kidx_q[KIDX_W-1:0]];
  end

  always_comb begin
    state_d     = state_q;
    gi_d        = gi_q;
    j_d         = j_q;
    a_d         = a_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    value_d     = value_q;
    last_d      = last_q;
    sched_d     = sched_q;
    len_d       = len_q;
    kidx_d      = kidx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    q_pop_o     = 1'b0;
    perm_clr    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = a_q;
    mem_wdata   = s_rdata;
    key_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          value_d = q_cmd_i.value;
          last_d  = q_cmd_i.last;
          if (q_cmd_i.kind == KIND_DATA) begin
            gi_d    = gi_q + 8'd1;
            a_d     = gi_q + 8'd1;
            sched_d = 1'b0;
            state_d = ST_RD_A;
          end else begin
            key_we = q_cmd_i.store;
            if (q_cmd_i.restart) begin
              gi_d = 8'd0;
              j_d  = 8'd0;
            end
            if (q_cmd_i.sched) begin
              perm_clr = 1'b1;
              a_d      = 8'd0;
              j_d      = 8'd0;
              kidx_d   = '0;
              len_d    = q_cmd_i.count;
              sched_d  = 1'b1;
              state_d  = ST_RD_A;
            end
          end
        end
      end
      ST_RD_A: begin
        mem_re   = 1'b1;
        mem_addr = a_q;
        state_d  = ST_RD_B;
      end
      ST_RD_B: begin
        mem_re   = 1'b1;
        mem_addr = j_new;
        j_d      = j_new;
        sa_d     = s_rdata;
        state_d  = ST_WR_A;
      end
      ST_WR_A: begin
        mem_we    = 1'b1;
        mem_addr  = a_q;
        mem_wdata = s_rdata;
        sb_d      = s_rdata;
        state_d   = ST_WR_B;
      end
      ST_WR_B: begin
        mem_we    = 1'b1;
        mem_addr  = j_q;
        mem_wdata = sa_q;
        if (!sched_q) begin
          state_d = ST_RD_T;
        end else if (a_q == 8'hff) begin
          gi_d    = 8'd0;
          j_d     = 8'd0;
          state_d = ST_IDLE;
        end else begin
          a_d     = a_q + 8'd1;
          kidx_d  = (kidx_q + KEY_CNT_W'(1) == len_q) ? '0 : kidx_q + KEY_CNT_W'(1);
          state_d = ST_RD_A;
        end
      end
      ST_RD_T: begin
        mem_re   = 1'b1;
        mem_addr = sa_q + sb_q;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_item_d.data_out = value_q ^ s_rdata;
          out_item_d.last_out = last_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gi_q        <= 8'd0;
      j_q         <= 8'd0;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gi_q        <= gi_d;
      j_q         <= j_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    value_q    <= value_d;
    last_q     <= last_d;
    len_q      <= len_d;
    kidx_q     <= kidx_d;
    out_item_q <= out_item_d;
  end

endmodule

>>> rtl/rc4_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher top level
// A data byte goes through the command queue and the RD_A, RD_B, WR_A, WR_B,
// RD_T and OUT states to the output register. No new data byte is taken until
// the last has made its five single-port accesses to the permutation memory.
// The last key byte runs the key schedule (4 memory accesses per step).
// Reset is asynchronous; the permutation reads as identity at once, no clearing.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top import rc4_pkg::*; #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd_out;

  rc4_front #(
    .KEY_MAX(KEY_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in)
  );

  rc4_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd_out)
  );

  rc4_core #(
    .KEY_MAX(KEY_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

>>> rtl/rc4_checker.sv
// ----------------------------------------------------------------------------
// RC4 port checker
// Watches the top-level ports and tracks data beats still owed a result.
// ----------------------------------------------------------------------------
module rc4_checker import rc4_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic       data_in;
  logic       data_out;
  logic [3:0] pending_q;

  assign data_in  = in_valid_i && !in_stall_o && (in_item_i.kind == KIND_DATA);
  assign data_out = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 4'd0;
    end else begin
      pending_q <= pending_q + 4'(data_in) - 4'(data_out);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output beat dropped or changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("output beat without an owed data beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd4)
    else $error("more data beats in flight than the design can hold");

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);
